@@ design/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_ctrl, tcw_datapath and the top level.
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_BKSP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
    logic       at_cursor;
    logic [7:0] attribute;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } dp_sts_t;

endpackage

@@ design/tcw_ctrl.sv @@
// Sequencing state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through dp_cmd_t / dp_sts_t.
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tcw_pkg::dp_cmd_t cmd_o,
  input  tcw_pkg::dp_sts_t sts_i
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    accept      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_sweep ? ST_SWEEP : ST_DONE;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          in_ready_o  = 1'b1;
          accept      = in_valid_i;
          state_d     = in_valid_i ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.capture = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/tcw_datapath.sv @@
// Cell buffer, cursor, address generation, scroll/clear sweep and result register.
// Depends on tcw_pkg; controlled by tcw_ctrl.
module tcw_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  tcw_pkg::in_item_t in_data_i,
  output tcw_pkg::out_item_t out_data_o,
  input  tcw_pkg::dp_cmd_t  cmd_i,
  output tcw_pkg::dp_sts_t  sts_o
);
  import tcw_pkg::*;

  typedef enum logic [1:0] {
    PEND_COPY,
    PEND_SPACE,
    PEND_ZERO
  } pend_e;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_q;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;

  logic [7:0]        dattr_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [COL_W-1:0]  cur_col_q;
  cmd_e              op_q;
  logic [7:0]        char_q, attr_q;
  logic [ROW_W-1:0]  tgt_row_q;
  logic [COL_W-1:0]  tgt_col_q;
  logic [ADDR_W-1:0] addr_q;
  logic              scrolled_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              pend_q;
  logic [ADDR_W-1:0] pend_addr_q;
  pend_e             pend_kind_q;
  out_item_t         out_q;

  // capture-side selection
  logic [COL_W-1:0]  sat_col, col_sel;
  logic [ROW_W-1:0]  sat_row, row_sel;
  logic [7:0]        attr_d, char_d;

  always_comb begin
    sat_col = (int'(in_data_i.col) >= COLS) ? COL_W'(COLS - 1) : COL_W'(in_data_i.col);
    sat_row = (int'(in_data_i.row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(in_data_i.row);
    row_sel = in_data_i.at_cursor ? cur_row_q : sat_row;
    col_sel = in_data_i.at_cursor ? cur_col_q : sat_col;
    attr_d  = dattr_q;
    char_d  = in_data_i.char_code;
    unique case (in_data_i.cmd)
      CMD_PUT: begin
        if (in_data_i.attribute != 8'd0) attr_d = in_data_i.attribute;
      end
      CMD_BKSP: begin
        char_d = CH_BACKSPACE;
        if (cur_col_q != '0) begin
          row_sel = cur_row_q;
          col_sel = cur_col_q - COL_W'(1);
        end else if (cur_row_q != '0) begin
          row_sel = cur_row_q - ROW_W'(1);
          col_sel = COL_W'(COLS - 1);
        end else begin
          row_sel = '0;
          col_sel = '0;
        end
      end
      CMD_CLEAR, CMD_READ: ;
      default: ;
    endcase
  end

  // execute-side cursor advance
  logic              newline, last_row, last_col, need_scroll, writes;
  logic [ROW_W-1:0]  nxt_row;
  logic [COL_W-1:0]  nxt_col;

  always_comb begin
    newline  = (op_q == CMD_PUT) && (char_q == CH_NEWLINE);
    last_row = (tgt_row_q == ROW_W'(ROWS - 1));
    last_col = (tgt_col_q == COL_W'(COLS - 1));
    writes   = ((op_q == CMD_PUT) && !newline) || (op_q == CMD_BKSP);
    need_scroll = last_row && (newline || last_col);
    if (need_scroll) begin
      nxt_row = ROW_W'(ROWS - 1);
      nxt_col = '0;
    end else if (newline || last_col) begin
      nxt_row = tgt_row_q + ROW_W'(1);
      nxt_col = '0;
    end else begin
      nxt_row = tgt_row_q;
      nxt_col = tgt_col_q + COL_W'(1);
    end
  end

  assign sts_o.need_sweep = (op_q == CMD_CLEAR) ||
                            (need_scroll && ((op_q == CMD_PUT) || (op_q == CMD_BKSP)));
  assign sts_o.sweep_last = (cnt_q == ADDR_W'(CELLS - 1));

  logic in_upper;
  assign in_upper = (int'(cnt_q) < CELLS - COLS);

  // memory ports
  always_comb begin
    raddr = addr_q;
    if (cmd_i.sweep && in_upper) raddr = cnt_q + ADDR_W'(COLS);
    we    = 1'b0;
    waddr = addr_q;
    wdata = {attr_q, char_q};
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      unique case (pend_kind_q)
        PEND_COPY:  wdata = rdata_q;
        PEND_SPACE: wdata = {dattr_q, CH_SPACE};
        PEND_ZERO:  wdata = '0;
        default:    wdata = '0;
      endcase
    end else if (cmd_i.exec && writes) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dattr_q   <= 8'd15;
      cur_row_q <= '0;
      cur_col_q <= '0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) dattr_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        if (writes || newline) begin
          cur_row_q <= nxt_row;
          cur_col_q <= nxt_col;
        end else if (op_q == CMD_CLEAR) begin
          cur_row_q <= '0;
          cur_col_q <= '0;
        end
      end
      pend_q <= cmd_i.sweep;
      if (cmd_i.capture) cnt_q <= '0;
      else if (cmd_i.sweep) cnt_q <= cnt_q + ADDR_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_data_i.cmd;
      char_q    <= char_d;
      attr_q    <= attr_d;
      tgt_row_q <= row_sel;
      tgt_col_q <= col_sel;
      addr_q    <= ADDR_W'(row_sel) * ADDR_W'(COLS) + ADDR_W'(col_sel);
    end
    if (cmd_i.exec) begin
      scrolled_q <= sts_o.need_sweep;
    end
    if (cmd_i.sweep) begin
      pend_addr_q <= cnt_q;
      if (!in_upper) pend_kind_q <= PEND_ZERO;
      else if (op_q == CMD_CLEAR) pend_kind_q <= PEND_SPACE;
      else pend_kind_q <= PEND_COPY;
    end
    if (cmd_i.load) begin
      out_q.cursor_col <= 7'(cur_col_q);
      out_q.cursor_row <= 5'(cur_row_q);
      out_q.scrolled   <= scrolled_q;
      out_q.read_char  <= (op_q == CMD_READ) ? rdata_q[7:0] : 8'd0;
      out_q.read_attr  <= (op_q == CMD_READ) ? rdata_q[15:8] : 8'd0;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ design/text_console_writer_with_scroll.sv @@
// Top level of the 80x25 text console writer with scroll.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage:
//   Items enter on in_valid_i/in_ready_o with an in_item_t payload (put,
//   backspace, clear, read). Each item gives one out_item_t result on
//   out_valid_o/out_ready_i: the cursor after the item, a scroll flag and,
//   for a read, the cell contents. The user must write default_attr through
//   cfg_we_i/cfg_wdata_i while the block is idle; this is not enforced.
// Sequence: each item is captured, executed, then loaded as its result;
//   an item that scrolls or a clear also sweeps and drains before the load.
// Throughput: a new item is taken only once the current one reaches its load;
//   an item that scrolls or a clear adds a sweep over every cell, paced by the
//   single write port of the cell buffer, one cell per cycle.
// Reset: cursor goes home, default_attr becomes 15; cell contents are not
//   cleared and must be written before they are read.
// Receiver stall: the result register holds the pending result; one more
//   item is accepted and executed, then intake stops until the result is
//   taken.
module text_console_writer_with_scroll (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_pkg::out_item_t out_data_o
);
  import tcw_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  tcw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.cursor_col) < COLS) &&
                    (int'(out_data_o.cursor_row) < ROWS))
    else $error("cursor out of range");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.scrolled) |->
      (out_data_o.cursor_col == '0) &&
      ((out_data_o.cursor_row == 5'(ROWS - 1)) || (out_data_o.cursor_row == '0)))
    else $error("scroll left cursor off a row start");

  a_no_intake_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.sweep |-> !in_ready_o)
    else $error("intake during sweep");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.sweep && dp_sts.sweep_last) |=> !dp_cmd.sweep)
    else $error("sweep ran past last cell");

endmodule
